// ===== hw/rtl/rslot_pkg.sv =====
package rslot_pkg;

  localparam int unsigned SLOTS_DEF = 16;

  localparam int unsigned POOL_W   = 5;
  localparam int unsigned RID_W    = 16;
  localparam int unsigned TAG_W    = 8;
  localparam int unsigned WHO_W    = 16;
  localparam int unsigned REFS_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOTIX_W = 4;

  localparam logic [POOL_W-1:0] POOL_RESET = POOL_W'(16);

  // request types
  localparam logic [1:0] REQ_REGISTER = 2'd0;
  localparam logic [1:0] REQ_ACQUIRE  = 2'd1;
  localparam logic [1:0] REQ_RELEASE  = 2'd2;
  localparam logic [1:0] REQ_CLEAR    = 2'd3;

  // response status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LIMIT    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOTHELD  = 3'd6;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  typedef struct packed {
    logic [RID_W-1:0]  resource;
    logic              tag_on;
    logic [TAG_W-1:0]  tag;
    logic [WHO_W-1:0]  owner;
    logic [REFS_W-1:0] refs;
  } slot_t;

endpackage

// ===== hw/rtl/rslot_cfg_if.sv =====
interface rslot_cfg_if import rslot_pkg::*;;
  logic              valid;
  logic              ready;
  logic [POOL_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rslot_req_if.sv =====
interface rslot_req_if import rslot_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [RID_W-1:0] resource_id;
  logic             has_tag;
  logic [TAG_W-1:0] tag_id;
  logic [WHO_W-1:0] requester_id;

  modport source (output valid, output req_type, output resource_id, output has_tag,
                  output tag_id, output requester_id, input ready);
  modport sink (input valid, input req_type, input resource_id, input has_tag,
                input tag_id, input requester_id, output ready);
endinterface

// ===== hw/rtl/rslot_rsp_if.sv =====
interface rslot_rsp_if import rslot_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOTIX_W-1:0] slot_index;
  logic                reused;
  logic [REFS_W-1:0]   ref_count;
  logic [POOL_W-1:0]   filled_count;

  modport source (output valid, output status, output slot_index, output reused,
                  output ref_count, output filled_count, input ready);
  modport sink (input valid, input status, input slot_index, input reused,
                input ref_count, input filled_count, output ready);
endinterface

// ===== hw/rtl/rslot_ram.sv =====
module rslot_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/reentrant_slot_pool.sv =====
// Reentrant slot pool: a table of SLOTS resource slots (id, optional tag, owner, reference
// count) held in one RAM with a registered read port and scanned one slot per cycle by a
// single shared compare unit. With L = min(filled slots, pool size), register and release
// scan up to L slots and acquire up to 2 * L slots (a re-entry pass over owned slots, then
// a claim pass over unowned ones); clear and an acquire with requester zero skip the scan.
// The RAM read port and the one comparator set this scan rate. The input is not ready while
// a request is in work; a finished response waits in an output register, so the next
// request is taken while it is pending. Slots are always filled from index 0 upward, so a
// fill count stands for the occupancy and the table needs no clearing pass after reset.
// The pool size must be written only while the block idles; the block does not enforce it.
module reentrant_slot_pool import rslot_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rslot_cfg_if.sink    cfg_i,
  rslot_req_if.sink    req_i,
  rslot_rsp_if.source  rsp_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned PW = (CW > POOL_W) ? CW : POOL_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [POOL_W-1:0]   pool_q;
  logic [CW-1:0]       fill_q, fill_d;
  logic [CW-1:0]       addr_q, addr_d;
  logic                dv_q, dv_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic                pass_q, pass_d;

  logic [1:0]          rq_type_q;
  logic [RID_W-1:0]    rq_rid_q;
  logic                rq_tagged_q;
  logic [TAG_W-1:0]    rq_tag_q;
  logic [WHO_W-1:0]    rq_who_q;

  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [IW-1:0]       res_slot_q, res_slot_d;
  logic                res_reused_q, res_reused_d;
  logic [REFS_W-1:0]   res_refs_q, res_refs_d;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SLOTIX_W-1:0] out_slot_q;
  logic                out_reused_q;
  logic [REFS_W-1:0]   out_refs_q;
  logic [POOL_W-1:0]   out_filled_q;

  logic [PW-1:0]       pool_ext;
  logic [PW-1:0]       act_ext;
  logic [CW-1:0]       act;
  logic [CW-1:0]       lim;
  slot_t               rd_slot;
  slot_t               wr_slot;
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic                ram_re;
  logic                tag_ok;
  logic                match;
  logic                hit;
  logic                pass_end;
  logic                req_acc;
  logic                out_load;

  assign req_acc     = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // clamp the pool size to 1..SLOTS
  assign pool_ext = PW'(pool_q);
  always_comb begin
    priority if (pool_ext == '0) begin
      act_ext = PW'(1);
    end else if (pool_ext > PW'(SLOTS)) begin
      act_ext = PW'(SLOTS);
    end else begin
      act_ext = pool_ext;
    end
  end
  assign act = CW'(act_ext);
  assign lim = (fill_q < act) ? fill_q : act;

  // shared compare unit
  assign tag_ok = rq_tagged_q ? (rd_slot.tag_on && (rd_slot.tag == rq_tag_q))
                              : !rd_slot.tag_on;
  always_comb begin
    unique case (rq_type_q)
      REQ_REGISTER: match = (rd_slot.resource == rq_rid_q);
      REQ_RELEASE:  match = (rd_slot.resource == rq_rid_q);
      REQ_ACQUIRE:  match = tag_ok && (pass_q ? (rd_slot.owner == '0)
                                              : (rd_slot.owner == rq_who_q));
      REQ_CLEAR:    match = 1'b0;
      default:      match = 1'b0;
    endcase
  end
  assign hit      = dv_q && match;
  assign pass_end = (addr_q >= lim);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    addr_d       = addr_q;
    dv_d         = dv_q;
    idx_d        = idx_q;
    pass_d       = pass_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_reused_d = res_reused_q;
    res_refs_d   = res_refs_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    wr_slot      = rd_slot;
    ram_re       = 1'b0;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          res_status_d = ST_OK;
          res_slot_d   = '0;
          res_reused_d = 1'b0;
          res_refs_d   = '0;
          addr_d       = '0;
          dv_d         = 1'b0;
          pass_d       = 1'b0;
          priority if (req_i.req_type == REQ_CLEAR) begin
            fill_d  = '0;
            state_d = S_FIN;
          end else if ((req_i.req_type == REQ_ACQUIRE) && (req_i.requester_id == '0)) begin
            res_status_d = ST_NONE;
            state_d      = S_FIN;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          res_slot_d = idx_q;
          state_d    = S_FIN;
          unique case (rq_type_q)
            REQ_REGISTER: begin
              res_status_d = ST_DUP;
              res_refs_d   = rd_slot.refs;
            end
            REQ_ACQUIRE: begin
              if (!pass_q) begin
                res_reused_d = 1'b1;
                if (rd_slot.refs == REFS_MAX) begin
                  res_status_d = ST_LIMIT;
                  res_refs_d   = REFS_MAX;
                end else begin
                  wr_slot.refs = rd_slot.refs + REFS_W'(1);
                  ram_we       = 1'b1;
                  res_status_d = ST_OK;
                  res_refs_d   = rd_slot.refs + REFS_W'(1);
                end
              end else begin
                wr_slot.owner = rq_who_q;
                wr_slot.refs  = REFS_W'(1);
                ram_we        = 1'b1;
                res_status_d  = ST_OK;
                res_refs_d    = REFS_W'(1);
              end
            end
            REQ_RELEASE: begin
              if (rd_slot.refs == '0) begin
                res_status_d = ST_NOTHELD;
                res_refs_d   = '0;
              end else begin
                wr_slot.refs = rd_slot.refs - REFS_W'(1);
                if (rd_slot.refs == REFS_W'(1)) begin
                  wr_slot.owner = '0;
                end
                ram_we       = 1'b1;
                res_status_d = ST_OK;
                res_refs_d   = rd_slot.refs - REFS_W'(1);
              end
            end
            REQ_CLEAR: begin
              res_status_d = ST_OK;
            end
            default: begin
              res_status_d = ST_OK;
            end
          endcase
        end else if (pass_end) begin
          unique case (rq_type_q)
            REQ_REGISTER: begin
              state_d = S_FIN;
              if (fill_q < act) begin
                ram_we           = 1'b1;
                ram_waddr        = fill_q[IW-1:0];
                wr_slot.resource = rq_rid_q;
                wr_slot.tag_on   = rq_tagged_q;
                wr_slot.tag      = rq_tagged_q ? rq_tag_q : '0;
                wr_slot.owner    = '0;
                wr_slot.refs     = '0;
                fill_d           = fill_q + CW'(1);
                res_status_d     = ST_OK;
                res_slot_d       = fill_q[IW-1:0];
              end else begin
                res_status_d = ST_FULL;
              end
            end
            REQ_ACQUIRE: begin
              if (!pass_q) begin
                // no owned slot: rescan for an unowned one
                pass_d = 1'b1;
                addr_d = '0;
                dv_d   = 1'b0;
              end else begin
                res_status_d = ST_NONE;
                state_d      = S_FIN;
              end
            end
            REQ_RELEASE: begin
              res_status_d = ST_NOTFOUND;
              state_d      = S_FIN;
            end
            REQ_CLEAR: begin
              state_d = S_FIN;
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end else begin
          // advance the read pointer; the compare runs in the cycle after the read
          ram_re = 1'b1;
          dv_d   = 1'b1;
          idx_d  = addr_q[IW-1:0];
          addr_d = addr_q + CW'(1);
        end
      end

      S_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  rslot_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_rslot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_slot),
    .re_i    (ram_re),
    .raddr_i (addr_q[IW-1:0]),
    .rdata_o (rd_slot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pool_q      <= POOL_RESET;
      fill_q      <= '0;
      addr_q      <= '0;
      dv_q        <= 1'b0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      addr_q  <= addr_d;
      dv_q    <= dv_d;
      pass_q  <= pass_d;
      if (cfg_i.valid && cfg_i.ready) begin
        pool_q <= cfg_i.data;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_reused_q <= res_reused_d;
    res_refs_q   <= res_refs_d;
    if (req_acc) begin
      rq_type_q   <= req_i.req_type;
      rq_rid_q    <= req_i.resource_id;
      rq_tagged_q <= req_i.has_tag;
      rq_tag_q    <= req_i.tag_id;
      rq_who_q    <= req_i.requester_id;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= SLOTIX_W'(res_slot_q);
      out_reused_q <= res_reused_q;
      out_refs_q   <= res_refs_q;
      out_filled_q <= POOL_W'(lim);
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.slot_index   = out_slot_q;
  assign rsp_o.reused       = out_reused_q;
  assign rsp_o.ref_count    = out_refs_q;
  assign rsp_o.filled_count = out_filled_q;

endmodule

// ===== hw/rtl/rslot_chk.sv =====
module rslot_chk import rslot_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [STATUS_W-1:0] status_i,
  input logic [SLOTIX_W-1:0] slot_index_i,
  input logic                reused_i,
  input logic [REFS_W-1:0]   ref_count_i,
  input logic [POOL_W-1:0]   filled_count_i
);

  // a stalled response holds its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) &&
      $stable(slot_index_i) && $stable(reused_i) && $stable(ref_count_i) &&
      $stable(filled_count_i))
    else $error("response changed while stalled");

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in work");

  // failures that touch no slot report slot 0 and count 0
  a_miss_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_FULL || status_i == ST_NONE || status_i == ST_NOTFOUND)
      |-> slot_index_i == '0 && ref_count_i == '0 && !reused_i)
    else $error("miss response carries slot data");

  // saturation only on re-entry at the top count
  a_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == ST_LIMIT |-> reused_i && ref_count_i == REFS_MAX)
    else $error("count limit without saturated re-entry");

  a_reused_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && reused_i |-> status_i == ST_OK || status_i == ST_LIMIT)
    else $error("re-entry flagged on a failed request");

endmodule

bind reentrant_slot_pool rslot_chk u_rslot_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .status_i       (rsp_o.status),
  .slot_index_i   (rsp_o.slot_index),
  .reused_i       (rsp_o.reused),
  .ref_count_i    (rsp_o.ref_count),
  .filled_count_i (rsp_o.filled_count)
);

// ===== dv/tb_reentrant_slot_pool.sv =====
module tb_reentrant_slot_pool;
  import rslot_pkg::*;

  localparam int unsigned NSLOTS      = SLOTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned DRAIN       = 60;
  localparam int unsigned HOLD_AT     = 700;
  localparam int unsigned HOLD_LEN    = 400;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOTIX_W-1:0] slot;
    logic                reused;
    logic [REFS_W-1:0]   refs;
    logic [POOL_W-1:0]   filled;
  } pool_answer_t;

  typedef struct packed {
    logic              is_cfg;
    logic [POOL_W-1:0] size;
    logic [1:0]        kind;
    logic [RID_W-1:0]  rid;
    logic              tag_on;
    logic [TAG_W-1:0]  tag;
    logic [WHO_W-1:0]  who;
  } pool_op_t;

  logic clk_i;
  logic rst_ni;

  rslot_cfg_if cfg_if ();
  rslot_req_if req_if ();
  rslot_rsp_if rsp_if ();

  reentrant_slot_pool i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow copy of the slot table
  logic [POOL_W-1:0] sh_pool_size;
  logic              sh_valid    [NSLOTS];
  logic [RID_W-1:0]  sh_resource [NSLOTS];
  logic              sh_tagged   [NSLOTS];
  logic [TAG_W-1:0]  sh_tag      [NSLOTS];
  logic [WHO_W-1:0]  sh_owner    [NSLOTS];
  logic [REFS_W-1:0] sh_refs     [NSLOTS];

  pool_op_t     req_plan [$];
  pool_answer_t answers_due [$];
  pool_op_t     cur_op;
  pool_answer_t want_ans;
  pool_answer_t got_ans;

  int unsigned reqs_taken;
  int unsigned answers_seen;
  int unsigned errors;
  int unsigned cycle_cnt;

  // sender pacing
  int unsigned tx_gap;
  int unsigned tx_settle;
  int unsigned tx_phase_left;
  bit          tx_quiet;
  logic        tx_req_valid;
  logic        tx_cfg_valid;

  // receiver pacing
  int unsigned rx_stall;
  int unsigned rx_hold;
  bit          rx_hold_done;
  int unsigned rx_phase_left;
  bit          rx_quiet;
  logic        rx_ready;

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    r = $urandom_range(99);
    if (quiet || r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int unsigned active_size();
    int unsigned n;
    n = 32'(sh_pool_size);
    if (n < 1) n = 1;
    if (n > NSLOTS) n = NSLOTS;
    return n;
  endfunction

  function automatic int unsigned leading_filled();
    int unsigned n;
    int unsigned c;
    bit gap_seen;
    n = active_size();
    c = 0;
    gap_seen = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!sh_valid[i]) gap_seen = 1'b1;
      if (!gap_seen) c++;
    end
    return c;
  endfunction

  function automatic bit tag_fits(int unsigned i, logic tag_on, logic [TAG_W-1:0] tag);
    if (!tag_on) return !sh_tagged[i];
    return sh_tagged[i] && sh_tag[i] == tag;
  endfunction

  // Apply one request to the shadow table and return the answer it must produce.
  function automatic pool_answer_t apply_pool_request(pool_op_t op);
    pool_answer_t a;
    int unsigned  n;
    int unsigned  lead;
    bit           done;
    n = active_size();
    lead = leading_filled();
    a = '0;
    a.status = ST_OK;
    done = 1'b0;
    case (op.kind)
      REQ_REGISTER: begin
        a.status = ST_FULL;
        for (int i = 0; i < n; i++) begin
          if (!done && sh_valid[i] && sh_resource[i] == op.rid) begin
            a.status = ST_DUP;
            a.slot   = SLOTIX_W'(i);
            a.refs   = sh_refs[i];
            done     = 1'b1;
          end else if (!done && !sh_valid[i]) begin
            sh_valid[i]    = 1'b1;
            sh_resource[i] = op.rid;
            sh_tagged[i]   = op.tag_on;
            sh_tag[i]      = op.tag_on ? op.tag : '0;
            sh_owner[i]    = '0;
            sh_refs[i]     = '0;
            a.status       = ST_OK;
            a.slot         = SLOTIX_W'(i);
            done           = 1'b1;
          end
        end
      end
      REQ_ACQUIRE: begin
        a.status = ST_NONE;
        if (op.who != '0) begin
          // re-enter an owned slot first
          for (int i = 0; i < lead; i++) begin
            if (!done && sh_owner[i] == op.who && tag_fits(i, op.tag_on, op.tag)) begin
              a.slot   = SLOTIX_W'(i);
              a.reused = 1'b1;
              done     = 1'b1;
              if (sh_refs[i] == REFS_MAX) begin
                a.status = ST_LIMIT;
              end else begin
                sh_refs[i] = sh_refs[i] + REFS_W'(1);
                a.status   = ST_OK;
              end
              a.refs = sh_refs[i];
            end
          end
          for (int i = 0; i < lead; i++) begin
            if (!done && sh_owner[i] == '0 && tag_fits(i, op.tag_on, op.tag)) begin
              sh_owner[i] = op.who;
              sh_refs[i]  = REFS_W'(1);
              a.status    = ST_OK;
              a.slot      = SLOTIX_W'(i);
              a.refs      = REFS_W'(1);
              done        = 1'b1;
            end
          end
        end
      end
      REQ_RELEASE: begin
        a.status = ST_NOTFOUND;
        for (int i = 0; i < n; i++) begin
          if (!done && sh_valid[i] && sh_resource[i] == op.rid) begin
            a.slot = SLOTIX_W'(i);
            done   = 1'b1;
            if (sh_refs[i] == '0) begin
              a.status = ST_NOTHELD;
            end else begin
              sh_refs[i] = sh_refs[i] - REFS_W'(1);
              if (sh_refs[i] == '0) sh_owner[i] = '0;
              a.status = ST_OK;
            end
            a.refs = sh_refs[i];
          end
        end
      end
      default: begin
        for (int i = 0; i < NSLOTS; i++) begin
          sh_valid[i] = 1'b0;
          sh_owner[i] = '0;
          sh_refs[i]  = '0;
        end
        a.status = ST_OK;
      end
    endcase
    a.filled = POOL_W'(leading_filled());
    return a;
  endfunction

  task automatic add_req(logic [1:0] kind, logic [RID_W-1:0] rid, logic tag_on,
                         logic [TAG_W-1:0] tag, logic [WHO_W-1:0] who);
    pool_op_t op;
    op = '0;
    op.kind = kind;
    op.rid = rid;
    op.tag_on = tag_on;
    op.tag = tag;
    op.who = who;
    req_plan.push_back(op);
  endtask

  task automatic add_cfg(logic [POOL_W-1:0] size);
    pool_op_t op;
    op = '0;
    op.is_cfg = 1'b1;
    op.size = size;
    req_plan.push_back(op);
  endtask

  // Mostly requests over small per-phase sets of ids, owners and tags so that
  // duplicates, re-entry and contention happen often; a few are pure noise.
  task automatic add_random_ops(int unsigned count);
    logic [RID_W-1:0] ids  [20];
    logic [WHO_W-1:0] whos [3];
    logic [TAG_W-1:0] tags [2];
    int unsigned      r;
    int unsigned      t;
    logic [RID_W-1:0] rid;
    logic [WHO_W-1:0] who;
    logic             tag_on;
    logic [TAG_W-1:0] tag;
    for (int k = 0; k < 20; k++) ids[k] = RID_W'($urandom);
    for (int k = 0; k < 3; k++) whos[k] = WHO_W'($urandom_range(65535, 1));
    for (int k = 0; k < 2; k++) tags[k] = TAG_W'($urandom);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 5) begin
        add_req(2'($urandom_range(3)), RID_W'($urandom), 1'($urandom_range(1)),
                TAG_W'($urandom), WHO_W'($urandom));
      end else begin
        rid = (r < 60) ? ids[$urandom_range(5)] : ids[$urandom_range(19)];
        who = ($urandom_range(99) == 0) ? '0 : whos[$urandom_range(2)];
        t = $urandom_range(2);
        tag_on = (t != 0);
        tag = tag_on ? tags[t-1] : TAG_W'($urandom);
        r = $urandom_range(99);
        if (r < 30) add_req(REQ_REGISTER, rid, tag_on, tag, who);
        else if (r < 66) add_req(REQ_ACQUIRE, rid, tag_on, tag, who);
        else if (r < 98) add_req(REQ_RELEASE, rid, tag_on, tag, who);
        else add_req(REQ_CLEAR, rid, tag_on, tag, who);
      end
    end
  endtask

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // sender: requests and pool size writes in plan order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        answers_due.push_back(apply_pool_request(cur_op));
        reqs_taken++;
      end
      if (cfg_if.valid && cfg_if.ready) sh_pool_size = cfg_if.data;

      if (tx_phase_left == 0) begin
        tx_phase_left = $urandom_range(300, 50);
        tx_quiet = ($urandom_range(3) == 0);
      end else begin
        tx_phase_left--;
      end

      // hold an offer that is not taken yet
      if (!((req_if.valid && !req_if.ready) || (cfg_if.valid && !cfg_if.ready))) begin
        tx_req_valid = 1'b0;
        tx_cfg_valid = 1'b0;
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (req_plan.size() != 0) begin
          if (req_plan[0].is_cfg) begin
            // write the pool size only once every answer is back
            if (reqs_taken != answers_seen) begin
              tx_settle = SETTLE;
            end else if (tx_settle != 0) begin
              tx_settle--;
            end else begin
              cur_op = req_plan.pop_front();
              cfg_if.data <= cur_op.size;
              tx_cfg_valid = 1'b1;
              tx_settle = SETTLE;
            end
          end else begin
            cur_op = req_plan.pop_front();
            req_if.req_type     <= cur_op.kind;
            req_if.resource_id  <= cur_op.rid;
            req_if.has_tag      <= cur_op.tag_on;
            req_if.tag_id       <= cur_op.tag;
            req_if.requester_id <= cur_op.who;
            tx_req_valid = 1'b1;
            tx_gap = pick_gap(tx_quiet);
          end
        end
        req_if.valid <= tx_req_valid;
        cfg_if.valid <= tx_cfg_valid;
      end
    end
  end

  // receiver: check answers in order and pace ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got_ans = {rsp_if.status, rsp_if.slot_index, rsp_if.reused, rsp_if.ref_count,
                   rsp_if.filled_count};
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected answer status %0d slot %0d reused %0d refs %0d filled %0d",
                   $time, got_ans.status, got_ans.slot, got_ans.reused, got_ans.refs,
                   got_ans.filled);
          errors++;
        end else begin
          want_ans = answers_due.pop_front();
          if (got_ans !== want_ans) begin
            $display("%0t: answer mismatch: expected status %0d slot %0d reused %0d refs %0d",
                     $time, want_ans.status, want_ans.slot, want_ans.reused, want_ans.refs,
                     " filled %0d, actual status %0d slot %0d reused %0d refs %0d filled %0d",
                     want_ans.filled, got_ans.status, got_ans.slot, got_ans.reused,
                     got_ans.refs, got_ans.filled);
            errors++;
          end
        end
        answers_seen <= answers_seen + 1;
      end

      if (rx_phase_left == 0) begin
        rx_phase_left = $urandom_range(300, 50);
        rx_quiet = ($urandom_range(3) == 0);
      end else begin
        rx_phase_left--;
      end

      if (rx_hold != 0) begin
        rx_hold--;
        rx_ready = 1'b0;
      end else if (!rx_hold_done && answers_seen >= HOLD_AT) begin
        // long back-pressure: let the block fill up and stall its input
        rx_hold_done = 1'b1;
        rx_hold = HOLD_LEN;
        rx_ready = 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall--;
        rx_ready = 1'b0;
      end else begin
        rx_ready = 1'b1;
        rx_stall = pick_gap(rx_quiet);
      end
      rsp_if.ready <= rx_ready;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [RID_W-1:0] sat_rid;
    logic [WHO_W-1:0] sat_who;
    logic [TAG_W-1:0] sat_tag;

    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = POOL_RESET;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_REGISTER;
    req_if.resource_id = '0;
    req_if.has_tag = 1'b0;
    req_if.tag_id = '0;
    req_if.requester_id = '0;
    rsp_if.ready = 1'b0;

    sh_pool_size = POOL_RESET;
    for (int i = 0; i < NSLOTS; i++) begin
      sh_valid[i] = 1'b0;
      sh_resource[i] = '0;
      sh_tagged[i] = 1'b0;
      sh_tag[i] = '0;
      sh_owner[i] = '0;
      sh_refs[i] = '0;
    end
    reqs_taken = 0;
    answers_seen = 0;
    errors = 0;
    cycle_cnt = 0;
    tx_gap = 0;
    tx_settle = SETTLE;
    tx_phase_left = 0;
    tx_quiet = 1'b0;
    rx_stall = 0;
    rx_hold = 0;
    rx_hold_done = 1'b0;
    rx_phase_left = 0;
    rx_quiet = 1'b0;

    // directed: empty pool, duplicates, tags, re-entry, release corners, clear
    add_req(REQ_RELEASE, 16'h0000, 1'b0, 8'h00, 16'h0001);
    add_req(REQ_ACQUIRE, 16'h0000, 1'b0, 8'h00, 16'h0001);
    add_req(REQ_REGISTER, 16'h0000, 1'b0, 8'hFF, 16'hFFFF);
    add_req(REQ_REGISTER, 16'hFFFF, 1'b1, 8'hFF, 16'h0001);
    add_req(REQ_REGISTER, 16'h1234, 1'b1, 8'h00, 16'h0001);
    add_req(REQ_REGISTER, 16'hFFFF, 1'b0, 8'h00, 16'h0001);
    add_req(REQ_RELEASE, 16'h0000, 1'b0, 8'h00, 16'h0001);
    add_req(REQ_ACQUIRE, 16'h0000, 1'b0, 8'hAA, 16'hFFFF);
    add_req(REQ_ACQUIRE, 16'h0000, 1'b0, 8'h55, 16'hFFFF);
    add_req(REQ_ACQUIRE, 16'h0000, 1'b1, 8'hFF, 16'h0001);
    add_req(REQ_ACQUIRE, 16'h0000, 1'b1, 8'h00, 16'h0001);
    add_req(REQ_ACQUIRE, 16'h0000, 1'b0, 8'h00, 16'h0000);
    add_req(REQ_ACQUIRE, 16'h0000, 1'b1, 8'h55, 16'h0002);
    add_req(REQ_ACQUIRE, 16'h0000, 1'b1, 8'hFF, 16'h0002);
    add_req(REQ_RELEASE, 16'h0000, 1'b0, 8'h00, 16'h0003);
    add_req(REQ_RELEASE, 16'h0000, 1'b0, 8'h00, 16'h0003);
    add_req(REQ_RELEASE, 16'h0000, 1'b0, 8'h00, 16'h0003);
    add_req(REQ_RELEASE, 16'hFFFF, 1'b0, 8'h00, 16'h0003);
    add_req(REQ_ACQUIRE, 16'h0000, 1'b0, 8'h00, 16'h8000);
    add_req(REQ_CLEAR, 16'hFFFF, 1'b1, 8'hFF, 16'hFFFF);
    add_req(REQ_RELEASE, 16'hFFFF, 1'b0, 8'h00, 16'h0001);

    // drive one slot's count into saturation, then step it back down
    sat_rid = RID_W'($urandom);
    sat_who = WHO_W'($urandom_range(65535, 1));
    sat_tag = TAG_W'($urandom);
    add_req(REQ_REGISTER, sat_rid, 1'b1, sat_tag, sat_who);
    repeat (257) add_req(REQ_ACQUIRE, sat_rid, 1'b1, sat_tag, sat_who);
    repeat (2) add_req(REQ_RELEASE, sat_rid, 1'b0, 8'h00, sat_who);
    add_req(REQ_ACQUIRE, sat_rid, 1'b1, sat_tag, sat_who);

    add_cfg(POOL_W'(1));
    add_random_ops(150);
    add_cfg(POOL_W'(0));
    add_random_ops(120);
    add_cfg(POOL_W'(31));
    add_random_ops(250);
    add_cfg(POOL_W'(4));
    add_random_ops(150);
    add_cfg(POOL_W'(17));
    add_random_ops(150);
    add_cfg(POOL_W'(8));
    add_random_ops(150);
    add_cfg(POOL_W'(16));
    add_random_ops(200);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_plan.size() != 0 || req_if.valid || cfg_if.valid
           || reqs_taken != answers_seen) begin
      @(posedge clk_i);
    end
    repeat (DRAIN) @(posedge clk_i);
    if (answers_due.size() != 0) begin
      $display("%0t: %0d answers never arrived", $time, answers_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
